// ===== rtl/core/npwt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// npwt_pkg
// Shared constants, types and codes of the nearest point search block.
// ----------------------------------------------------------------------------
package npwt_pkg;

    // Table size and the widths that follow from it.
    localparam int MAX_POINTS = 1024;
    localparam int PTR_W      = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CNT_W      = $clog2(MAX_POINTS + 1);

    // Field widths.
    localparam int COORD_W = 30;
    localparam int WORD_W  = 32;
    localparam int IDX_W   = 10;
    localparam int SQ_W    = 2 * COORD_W;
    localparam int DIST_W  = SQ_W + 1;
    localparam int TOL_W   = 30;

    localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(1250);

    // Request queue between the front and the back; depth is a power of two.
    localparam int QUEUE_DEPTH = 2;
    localparam int Q_PTR_W     = $clog2(QUEUE_DEPTH);
    localparam int Q_CNT_W     = $clog2(QUEUE_DEPTH + 1);

    // Request kinds.
    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // Configuration port.
    localparam int   APB_ADDR_W    = 3;
    localparam int   APB_DATA_W    = 32;
    localparam logic REG_TOLERANCE = 1'b0;

    // One stored point; x sits in the lowest bits.
    typedef struct packed {
        logic [WORD_W-1:0]  delta;
        logic [WORD_W-1:0]  time_val;
        logic [COORD_W-1:0] y;
        logic [COORD_W-1:0] x;
    } point_t;

    // A classified request as it travels through the queue.
    typedef struct packed {
        logic   op;
        point_t pt;
    } cmd_t;

    // One match result; x sits in the lowest bits.
    typedef struct packed {
        logic [DIST_W-1:0]  dist_sq;
        logic [IDX_W-1:0]   index;
        logic [WORD_W-1:0]  delta;
        logic [WORD_W-1:0]  time_val;
        logic [COORD_W-1:0] y;
        logic [COORD_W-1:0] x;
    } result_t;

    localparam int POINT_W    = $bits(point_t);
    localparam int RESULT_W   = $bits(result_t);
    localparam int IN_DATA_W  = ((POINT_W + 7) / 8) * 8;
    localparam int OUT_DATA_W = ((RESULT_W + 7) / 8) * 8;

endpackage

// ===== rtl/core/npwt_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// npwt_front
// Accepts input requests, classifies them as loads or queries and holds
// them in a short queue for the back end.
// ----------------------------------------------------------------------------
module npwt_front
    import npwt_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [IN_DATA_W-1:0] s_tdata,   // coord_x, coord_y, time_payload, delta_payload
    input  logic                 s_tuser,   // kind
    output logic                 q_valid,
    output cmd_t                 q_cmd,
    input  logic                 q_pop
);

    cmd_t               fifo_reg [QUEUE_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg;
    logic [Q_PTR_W-1:0] rd_ptr_reg;
    logic [Q_CNT_W-1:0] fill_reg;
    logic [Q_CNT_W-1:0] fill_next;
    logic               push;
    logic               pop;
    cmd_t               in_cmd;

    // Classify the incoming request.
    always_comb
    begin
        in_cmd.op = (s_tuser == OP_QUERY) ? OP_QUERY : OP_LOAD;
        in_cmd.pt = s_tdata[POINT_W-1:0];
    end

    assign s_tready = (fill_reg != Q_CNT_W'(QUEUE_DEPTH));
    assign q_valid  = (fill_reg != '0);
    assign q_cmd    = fifo_reg[rd_ptr_reg];
    assign push     = s_tvalid && s_tready;
    assign pop      = q_pop && q_valid;

    // Occupancy of the queue.
    always_comb
    begin
        fill_next = fill_reg;
        if (push && !pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    // Queue pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            fill_reg <= fill_next;
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    // Queue storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_reg[wr_ptr_reg] <= in_cmd;
        end
    end

endmodule

// ===== rtl/core/npwt_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// npwt_back
// Stores loaded points in the table memory, runs the nearest point scan for
// queries through a short distance pipeline and delivers a match within tolerance.
// ----------------------------------------------------------------------------
module npwt_back
    import npwt_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  q_valid,
    input  cmd_t                  q_cmd,
    output logic                  q_pop,
    input  logic [TOL_W-1:0]      tolerance,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_SCAN   = 3'd1;
    localparam logic [2:0] ST_DRAIN  = 3'd2;
    localparam logic [2:0] ST_FETCH  = 3'd3;
    localparam logic [2:0] ST_RESULT = 3'd4;

    function automatic logic [COORD_W-1:0] abs_diff(input logic [COORD_W-1:0] a,
                                                    input logic [COORD_W-1:0] b);
        return (a >= b) ? (a - b) : (b - a);
    endfunction

    logic [2:0]         state_reg;
    logic [2:0]         state_next;
    logic [CNT_W-1:0]   count_reg;
    logic [PTR_W-1:0]   scan_addr_reg;
    logic [COORD_W-1:0] qx_reg;
    logic [COORD_W-1:0] qy_reg;
    logic [SQ_W-1:0]    tol_sq_reg;

    // Table memory.
    point_t             mem [MAX_POINTS];
    point_t             rd_data_reg;
    logic               mem_we;
    logic               rd_en;
    logic [PTR_W-1:0]   rd_addr;

    // Distance pipeline.
    logic               p1_valid_reg;
    logic [PTR_W-1:0]   p1_idx_reg;
    logic               p2_valid_reg;
    logic [PTR_W-1:0]   p2_idx_reg;
    logic [COORD_W-1:0] dx_reg;
    logic [COORD_W-1:0] dy_reg;
    logic               p3_valid_reg;
    logic [PTR_W-1:0]   p3_idx_reg;
    logic [SQ_W-1:0]    sqx_reg;
    logic [SQ_W-1:0]    sqy_reg;
    logic [DIST_W-1:0]  dist_sum;

    // Best candidate so far.
    logic               best_valid_reg;
    logic [PTR_W-1:0]   best_idx_reg;
    logic [DIST_W-1:0]  best_dist_reg;

    // Output register.
    logic               m_valid_reg;
    result_t            m_data_reg;
    logic               out_free;
    logic               out_load;
    logic               scan_last;
    logic               pipe_busy;
    logic               within_tol;
    result_t            res;

    assign q_pop      = (state_reg == ST_IDLE) && q_valid;
    assign out_free   = !m_valid_reg || m_tready;
    assign scan_last  = (CNT_W'(scan_addr_reg) == (count_reg - CNT_W'(1)));
    assign pipe_busy  = p1_valid_reg || p2_valid_reg || p3_valid_reg;
    assign within_tol = (best_dist_reg <= DIST_W'(tol_sq_reg));
    assign out_load   = (state_reg == ST_RESULT) && out_free;
    assign mem_we     = q_pop && (q_cmd.op == OP_LOAD) && (count_reg < CNT_W'(MAX_POINTS));
    assign dist_sum   = DIST_W'(sqx_reg) + DIST_W'(sqy_reg);

    // Read port: scan address during the sweep, best index when fetching.
    always_comb
    begin
        rd_en   = 1'b0;
        rd_addr = scan_addr_reg;
        case (state_reg)
            ST_SCAN:
            begin
                rd_en = 1'b1;
            end
            ST_FETCH:
            begin
                rd_en   = within_tol;
                rd_addr = best_idx_reg;
            end
            default:
            begin
                rd_en = 1'b0;
            end
        endcase
    end

    // Sequencer.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (q_pop && (q_cmd.op == OP_QUERY) && (count_reg != '0))
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (scan_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (!pipe_busy)
                begin
                    state_next = ST_FETCH;
                end
            end
            ST_FETCH:
            begin
                state_next = within_tol ? ST_RESULT : ST_IDLE;
            end
            ST_RESULT:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            count_reg      <= '0;
            p1_valid_reg   <= 1'b0;
            p2_valid_reg   <= 1'b0;
            p3_valid_reg   <= 1'b0;
            best_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            p1_valid_reg <= (state_reg == ST_SCAN);
            p2_valid_reg <= p1_valid_reg;
            p3_valid_reg <= p2_valid_reg;
            if (mem_we)
            begin
                count_reg <= count_reg + 1'b1;
            end
            if (q_pop)
            begin
                best_valid_reg <= 1'b0;
            end
            else if (p3_valid_reg)
            begin
                best_valid_reg <= 1'b1;
            end
            if (out_load)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Query setup, scan address and distance pipeline.
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            qx_reg        <= q_cmd.pt.x;
            qy_reg        <= q_cmd.pt.y;
            tol_sq_reg    <= SQ_W'(tolerance) * SQ_W'(tolerance);
            scan_addr_reg <= '0;
        end
        else if (state_reg == ST_SCAN)
        begin
            scan_addr_reg <= scan_addr_reg + 1'b1;
        end
        p1_idx_reg <= scan_addr_reg;
        p2_idx_reg <= p1_idx_reg;
        dx_reg     <= abs_diff(qx_reg, rd_data_reg.x);
        dy_reg     <= abs_diff(qy_reg, rd_data_reg.y);
        p3_idx_reg <= p2_idx_reg;
        sqx_reg    <= SQ_W'(dx_reg) * SQ_W'(dx_reg);
        sqy_reg    <= SQ_W'(dy_reg) * SQ_W'(dy_reg);
        // Strict compare keeps the lowest index on ties.
        if (p3_valid_reg && (!best_valid_reg || (dist_sum < best_dist_reg)))
        begin
            best_idx_reg  <= p3_idx_reg;
            best_dist_reg <= dist_sum;
        end
    end

    // Table memory, one write and one registered read port.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[count_reg[PTR_W-1:0]] <= q_cmd.pt;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // Assemble the match from the fetched entry.
    always_comb
    begin
        res.x        = rd_data_reg.x;
        res.y        = rd_data_reg.y;
        res.time_val = rd_data_reg.time_val;
        res.delta    = rd_data_reg.delta;
        res.index    = IDX_W'(best_idx_reg);
        res.dist_sq  = best_dist_reg;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            m_data_reg <= res;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = OUT_DATA_W'(m_data_reg);

endmodule

// ===== rtl/core/nearest_point_within_tolerance.sv =====
`timescale 1ns / 1ps
// Loads stream at one per cycle while no query is in the back end. The back end
// takes the next request only when a query has ended: the scan reads one table
// entry a cycle through the single read port of the table memory.
// Reset empties the table and the queue, drops any pending result and sets
// the tolerance to 1250; the table memory itself is not cleared.
// ----------------------------------------------------------------------------
// nearest_point_within_tolerance
// Brute-force 2-D nearest neighbor search over a table of loaded points,
// reporting the nearest point when it lies within the configured tolerance.
// ----------------------------------------------------------------------------
module nearest_point_within_tolerance
    import npwt_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    // Configuration port
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    // Request stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,   // coord_x, coord_y, time_payload, delta_payload
    input  logic                  s_tuser,   // kind
    // Result stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata    // match_x, match_y, match_time, match_delta,
                                             // match_index, match_dist_sq
);

    logic [TOL_W-1:0] tol_reg;
    logic             cfg_write;
    logic             q_valid;
    logic             q_pop;
    cmd_t             q_cmd;

    // Register file: the tolerance register.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready && (paddr[2] == REG_TOLERANCE);
    assign prdata    = (paddr[2] == REG_TOLERANCE) ? APB_DATA_W'(tol_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tol_reg <= TOL_RESET;
        end
        else if (cfg_write)
        begin
            tol_reg <= pwdata[TOL_W-1:0];
        end
    end

    npwt_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_valid  (q_valid),
        .q_cmd    (q_cmd),
        .q_pop    (q_pop)
    );

    npwt_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_cmd     (q_cmd),
        .q_pop     (q_pop),
        .tolerance (tol_reg),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

// ===== rtl/core/npwt_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// npwt_checker
// Port-level checks of the nearest point search block over time.
// ----------------------------------------------------------------------------
module npwt_checker
    import npwt_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  psel,
    input logic                  penable,
    input logic                  pwrite,
    input logic [APB_ADDR_W-1:0] paddr,
    input logic [APB_DATA_W-1:0] pwdata,
    input logic [APB_DATA_W-1:0] prdata,
    input logic                  pready,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [OUT_DATA_W-1:0] m_tdata
);

    // A stalled result keeps its value.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // A written tolerance reads back on the following cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (psel && penable && pwrite && pready && (paddr[2] == REG_TOLERANCE))
        ##1 (paddr[2] == REG_TOLERANCE)
        |-> prdata == APB_DATA_W'($past(pwdata[TOL_W-1:0])))
        else $error("tolerance readback mismatch");

    // No result is offered while reset is held.
    assert property (@(posedge clk) !rst_n |-> !m_tvalid)
        else $error("result valid during reset");

    // Padding bits above the result fields stay zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata >> RESULT_W) == '0)
        else $error("result padding not zero");

endmodule

bind nearest_point_within_tolerance npwt_checker u_npwt_checker (.*);

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the nearest point search block. Loads and queries
// are streamed in with random bursts and gaps while the result side stalls on
// its own pattern. A behavioral nearest point search or a directed table entry
// predicts every match, which is compared field by field with the block's output.
// ----------------------------------------------------------------------------
module testbench;
    import npwt_pkg::*;

    localparam int CYCLE_LIMIT = 2_000_000;
    localparam int HOLD_CYCLES = 2000;
    localparam int SEGMENT_ITEMS = 48;
    localparam int SEGMENTS = 9;
    localparam longint COORD_MAX = (64'd1 << COORD_W) - 1;
    localparam logic [COORD_W-1:0] CMAX = {COORD_W{1'b1}};
    localparam logic [TOL_W-1:0] TOL_MAX = {TOL_W{1'b1}};
    localparam logic [APB_ADDR_W-1:0] TOL_ADDR = APB_ADDR_W'(4 * REG_TOLERANCE);
    localparam logic [APB_ADDR_W-1:0] UNUSED_ADDR = APB_ADDR_W'(4 * (REG_TOLERANCE + 1));

    // Directed table entries and how their result is known.
    typedef enum {ROW_LOAD, ROW_QUERY, ROW_TOL} row_op_t;
    typedef enum {EXP_MODEL, EXP_NOTHING, EXP_TYPED} row_exp_t;

    typedef struct {
        row_op_t  op;
        point_t   pt;
        row_exp_t how;
        result_t  match;
    } dir_row_t;

    logic                  clk;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata;
    logic                  s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;

    // Shadow copy of the point table and the tolerance register.
    logic [COORD_W-1:0] tbl_x [MAX_POINTS];
    logic [COORD_W-1:0] tbl_y [MAX_POINTS];
    logic [WORD_W-1:0]  tbl_time [MAX_POINTS];
    logic [WORD_W-1:0]  tbl_delta [MAX_POINTS];
    int                 stored_count = 0;
    logic [TOL_W-1:0]   tolerance = TOL_RESET;

    result_t pending_matches[$];
    logic [COORD_W-1:0] centers [4];

    int error_count = 0;
    int loads_sent = 0;
    int loads_dropped = 0;
    int queries_sent = 0;
    int matches_seen = 0;
    int tol_settings = 0;
    int hold_off_cycles = 0;
    int burst_left = 0;
    bit pace_on = 1'b1;

    nearest_point_within_tolerance i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // 50 MHz clock.
    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // Stop a hung run.
    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("RESULT: ERROR");
        $finish;
    end

    // Append a point unless the table is full.
    function automatic void store_point(input point_t p);
        if (stored_count < MAX_POINTS)
        begin
            tbl_x[stored_count] = p.x;
            tbl_y[stored_count] = p.y;
            tbl_time[stored_count] = p.time_val;
            tbl_delta[stored_count] = p.delta;
            stored_count++;
        end
        else
        begin
            loads_dropped++;
        end
    endfunction

    // Scan all stored points for the nearest one; first position wins ties.
    function automatic bit find_nearest(input logic [COORD_W-1:0] qx,
                                        input logic [COORD_W-1:0] qy,
                                        output result_t m);
        logic [63:0] dx;
        logic [63:0] dy;
        logic [63:0] d;
        logic [63:0] best_d;
        logic [63:0] tol_sq;
        int i;
        int best_i;
        bit found;
        found = 1'b0;
        best_d = '0;
        best_i = 0;
        m = '0;
        for (i = 0; i < stored_count; i++)
        begin
            dx = (qx >= tbl_x[i]) ? qx - tbl_x[i] : tbl_x[i] - qx;
            dy = (qy >= tbl_y[i]) ? qy - tbl_y[i] : tbl_y[i] - qy;
            d = dx * dx + dy * dy;
            if (!found || d < best_d)
            begin
                found = 1'b1;
                best_d = d;
                best_i = i;
            end
        end
        // The square root is avoided by comparing with the squared tolerance.
        tol_sq = 64'(tolerance) * 64'(tolerance);
        if (!found || best_d > tol_sq)
            return 1'b0;
        m.x = tbl_x[best_i];
        m.y = tbl_y[best_i];
        m.time_val = tbl_time[best_i];
        m.delta = tbl_delta[best_i];
        m.index = IDX_W'(best_i);
        m.dist_sq = best_d[DIST_W-1:0];
        return 1'b1;
    endfunction

    function automatic result_t hit(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y,
                                    input logic [WORD_W-1:0] t, input logic [WORD_W-1:0] d,
                                    input int idx, input longint unsigned sq_dist);
        result_t r;
        r.x = x;
        r.y = y;
        r.time_val = t;
        r.delta = d;
        r.index = IDX_W'(idx);
        r.dist_sq = DIST_W'(sq_dist);
        return r;
    endfunction

    function automatic dir_row_t mk_row(input row_op_t op, input logic [COORD_W-1:0] x,
                                        input logic [COORD_W-1:0] y, input logic [WORD_W-1:0] t,
                                        input logic [WORD_W-1:0] d, input row_exp_t how,
                                        input result_t match);
        dir_row_t r;
        r.op = op;
        r.pt.x = x;
        r.pt.y = y;
        r.pt.time_val = t;
        r.pt.delta = d;
        r.how = how;
        r.match = match;
        return r;
    endfunction

    function automatic logic [COORD_W-1:0] jitter(input logic [COORD_W-1:0] base,
                                                  input int unsigned spread);
        longint v;
        v = longint'(base) + longint'($urandom_range(0, 2 * spread)) - longint'(spread);
        if (v < 0)
            v = 0;
        else if (v > COORD_MAX)
            v = COORD_MAX;
        return v[COORD_W-1:0];
    endfunction

    // Query close to a stored point, from exact hits to well outside.
    function automatic cmd_t near_query();
        cmd_t c;
        int unsigned i;
        int unsigned spread;
        c.op = OP_QUERY;
        c.pt.time_val = $urandom();
        c.pt.delta = $urandom();
        if (stored_count == 0)
        begin
            c.pt.x = COORD_W'($urandom());
            c.pt.y = COORD_W'($urandom());
            return c;
        end
        i = $urandom_range(0, stored_count - 1);
        case ($urandom_range(0, 3))
            0: spread = 0;
            1: spread = 50;
            2: spread = 1500;
            default: spread = 6000;
        endcase
        c.pt.x = jitter(tbl_x[i], spread);
        c.pt.y = jitter(tbl_y[i], spread);
        return c;
    endfunction

    // Load near one of the cluster centers, now and then anywhere.
    function automatic cmd_t random_load();
        cmd_t c;
        int unsigned k;
        c.op = OP_LOAD;
        c.pt.time_val = $urandom();
        c.pt.delta = $urandom();
        if ($urandom_range(0, 4) == 0)
        begin
            c.pt.x = COORD_W'($urandom());
            c.pt.y = COORD_W'($urandom());
        end
        else
        begin
            k = $urandom_range(0, 3);
            c.pt.x = jitter(centers[k], 3000);
            c.pt.y = jitter(centers[k], 3000);
        end
        return c;
    endfunction

    // Mostly clustered loads and near queries, with some far-off noise.
    function automatic cmd_t random_request();
        cmd_t c;
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 40 || stored_count == 0)
        begin
            c = random_load();
        end
        else if (pick < 90)
        begin
            c = near_query();
        end
        else
        begin
            c.op = OP_QUERY;
            c.pt.x = COORD_W'($urandom());
            c.pt.y = COORD_W'($urandom());
            c.pt.time_val = $urandom();
            c.pt.delta = $urandom();
        end
        return c;
    endfunction

    // One configuration transfer: setup cycle, then access until pready.
    task automatic apb_transfer(input bit is_write, input logic [APB_ADDR_W-1:0] addr,
                                input logic [APB_DATA_W-1:0] wdata,
                                output logic [APB_DATA_W-1:0] rdata);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= is_write;
        paddr <= addr;
        pwdata <= wdata;
        @(posedge clk);
        penable <= 1'b1;
        forever
        begin
            @(negedge clk);
            if (pready)
                break;
            @(posedge clk);
        end
        rdata = prdata;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic check_tolerance_readback();
        logic [APB_DATA_W-1:0] rd;
        apb_transfer(1'b0, TOL_ADDR, '0, rd);
        if (rd[TOL_W-1:0] !== tolerance)
        begin
            $error("tolerance_cm readback: expected %0d, actual %0d", tolerance, rd[TOL_W-1:0]);
            error_count++;
        end
    endtask

    // Wait for every pending match, then for any query still scanning.
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (pending_matches.size() != 0)
            @(posedge clk);
        repeat (3 * (stored_count + 8) + 16) @(posedge clk);
    endtask

    task automatic set_tolerance(input logic [TOL_W-1:0] value);
        logic [APB_DATA_W-1:0] wdata;
        logic [APB_DATA_W-1:0] rd;
        wait_idle();
        // Upper data bits are random; only the low bits hold the register.
        wdata = $urandom();
        wdata[TOL_W-1:0] = value;
        apb_transfer(1'b1, TOL_ADDR, wdata, rd);
        tolerance = value;
        tol_settings++;
        check_tolerance_readback();
    endtask

    // Sender pacing: bursts of random length separated by random gaps.
    task automatic pace();
        int unsigned gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            if ($urandom_range(0, 3) == 0)
                gap = 0;
            else
                gap = $urandom_range(1, ($urandom_range(0, 4) == 0) ? 60 : 6);
            if (gap != 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
    endtask

    // Offer one request and record what it should produce once accepted.
    task automatic send(input cmd_t c, input row_exp_t how, input result_t typed);
        result_t m;
        if (pace_on)
            pace();
        s_tvalid <= 1'b1;
        s_tuser <= c.op;
        s_tdata <= IN_DATA_W'(c.pt);
        forever
        begin
            @(negedge clk);
            if (s_tready)
                break;
            @(posedge clk);
        end
        if (c.op == OP_LOAD)
        begin
            store_point(c.pt);
            loads_sent++;
        end
        else
        begin
            queries_sent++;
            if (how == EXP_TYPED)
                pending_matches.push_back(typed);
            else if (how == EXP_MODEL && find_nearest(c.pt.x, c.pt.y, m))
                pending_matches.push_back(m);
        end
        @(posedge clk);
    endtask

    function automatic void check_field(input string name, input logic [63:0] want,
                                        input logic [63:0] got);
        if (got !== want)
        begin
            $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
            error_count++;
        end
    endfunction

    // Result side: compare each accepted match with the oldest expectation.
    always @(negedge clk)
    begin : match_monitor
        result_t got;
        result_t want;
        if (m_tvalid && m_tready)
        begin
            got = m_tdata[RESULT_W-1:0];
            matches_seen++;
            if (pending_matches.size() == 0)
            begin
                $error("unexpected match: index %0d dist_sq %0d", got.index, got.dist_sq);
                error_count++;
            end
            else
            begin
                want = pending_matches.pop_front();
                check_field("match_x", 64'(want.x), 64'(got.x));
                check_field("match_y", 64'(want.y), 64'(got.y));
                check_field("match_time", 64'(want.time_val), 64'(got.time_val));
                check_field("match_delta", 64'(want.delta), 64'(got.delta));
                check_field("match_index", 64'(want.index), 64'(got.index));
                check_field("match_dist_sq", 64'(want.dist_sq), 64'(got.dist_sq));
            end
        end
    end

    // Result side ready: changing stall styles, plus one long hold-off on request.
    initial
    begin : result_ready
        int unsigned style;
        int unsigned run_left;
        bit ready;
        style = 0;
        run_left = 0;
        m_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_off_cycles != 0)
            begin
                m_tready <= 1'b0;
                repeat (hold_off_cycles) @(posedge clk);
                hold_off_cycles = 0;
            end
            if (run_left == 0)
            begin
                style = $urandom_range(0, 3);
                run_left = $urandom_range(5, 60);
            end
            run_left--;
            case (style)
                0: ready = 1'b1;
                1: ready = $urandom_range(0, 1);
                2: ready = ($urandom_range(0, 9) != 0);
                default: ready = ($urandom_range(0, 5) == 0);
            endcase
            m_tready <= ready;
        end
    end

    // Main sequence: reset, directed table, random segments, full table.
    initial
    begin : stimulus
        dir_row_t directed_rows[$];
        dir_row_t row;
        result_t none;
        logic [APB_DATA_W-1:0] rd;
        logic [TOL_W-1:0] seg_tol;
        int r;
        int seg;
        int n;

        none = '0;
        rst_n <= 1'b0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        s_tvalid <= 1'b0;
        s_tdata <= '0;
        s_tuser <= OP_LOAD;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Tolerance after reset, and a write to an unused register is ignored.
        check_tolerance_readback();
        apb_transfer(1'b1, UNUSED_ADDR, $urandom(), rd);
        check_tolerance_readback();

        // Directed table. Tolerance starts at its reset value of 12.50 m.
        directed_rows.push_back(mk_row(ROW_QUERY, 0, 0, 0, 0, EXP_NOTHING, none));
        directed_rows.push_back(mk_row(ROW_QUERY, CMAX, CMAX, 0, 0, EXP_NOTHING, none));
        directed_rows.push_back(mk_row(ROW_LOAD, 0, 0, 32'h8000_0000, 32'h7FFF_FFFF,
                                       EXP_MODEL, none));
        directed_rows.push_back(mk_row(ROW_QUERY, 0, 0, 0, 0, EXP_TYPED,
                                       hit(0, 0, 32'h8000_0000, 32'h7FFF_FFFF, 0, 0)));
        // Exactly on the tolerance, then one unit beyond it.
        directed_rows.push_back(mk_row(ROW_QUERY, 1250, 0, 0, 0, EXP_TYPED,
                                       hit(0, 0, 32'h8000_0000, 32'h7FFF_FFFF, 0, 1562500)));
        directed_rows.push_back(mk_row(ROW_QUERY, 1251, 0, 0, 0, EXP_NOTHING, none));
        directed_rows.push_back(mk_row(ROW_QUERY, 750, 1000, 0, 0, EXP_TYPED,
                                       hit(0, 0, 32'h8000_0000, 32'h7FFF_FFFF, 0, 1562500)));
        directed_rows.push_back(mk_row(ROW_LOAD, CMAX, CMAX, 32'h7FFF_FFFF, 32'h8000_0000,
                                       EXP_MODEL, none));
        directed_rows.push_back(mk_row(ROW_QUERY, CMAX, CMAX, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                       EXP_TYPED,
                                       hit(CMAX, CMAX, 32'h7FFF_FFFF, 32'h8000_0000, 1, 0)));
        directed_rows.push_back(mk_row(ROW_QUERY, CMAX, 0, 0, 0, EXP_NOTHING, none));
        // Two points at the same place: the earlier one wins.
        directed_rows.push_back(mk_row(ROW_LOAD, 1000, 1000, 32'hFFFF_FFFF, 0,
                                       EXP_MODEL, none));
        directed_rows.push_back(mk_row(ROW_LOAD, 1000, 1000, 1, 2, EXP_MODEL, none));
        directed_rows.push_back(mk_row(ROW_QUERY, 1000, 1000, 0, 0, EXP_TYPED,
                                       hit(1000, 1000, 32'hFFFF_FFFF, 0, 2, 0)));
        directed_rows.push_back(mk_row(ROW_LOAD, 2000, 1000, 5, 6, EXP_MODEL, none));
        directed_rows.push_back(mk_row(ROW_QUERY, 1500, 1000, 0, 0, EXP_MODEL, none));
        directed_rows.push_back(mk_row(ROW_QUERY, 1700, 900, 0, 0, EXP_MODEL, none));
        // Zero tolerance accepts only exact hits.
        directed_rows.push_back(mk_row(ROW_TOL, 0, 0, 0, 0, EXP_MODEL, none));
        directed_rows.push_back(mk_row(ROW_QUERY, 1000, 1000, 0, 0, EXP_TYPED,
                                       hit(1000, 1000, 32'hFFFF_FFFF, 0, 2, 0)));
        directed_rows.push_back(mk_row(ROW_QUERY, 1000, 1001, 0, 0, EXP_NOTHING, none));
        // Largest tolerance.
        directed_rows.push_back(mk_row(ROW_TOL, TOL_MAX, 0, 0, 0, EXP_MODEL, none));
        directed_rows.push_back(mk_row(ROW_QUERY, CMAX, 0, 0, 0, EXP_MODEL, none));
        directed_rows.push_back(mk_row(ROW_QUERY, 0, CMAX, 0, 0, EXP_MODEL, none));
        directed_rows.push_back(mk_row(ROW_LOAD, 12345, 67890, 32'h55AA_55AA, 32'hAA55_AA55,
                                       EXP_MODEL, none));
        directed_rows.push_back(mk_row(ROW_TOL, TOL_RESET, 0, 0, 0, EXP_MODEL, none));
        directed_rows.push_back(mk_row(ROW_QUERY, 12000, 68000, 0, 0, EXP_MODEL, none));

        for (r = 0; r < directed_rows.size(); r++)
        begin
            row = directed_rows[r];
            if (row.op == ROW_TOL)
                set_tolerance(row.pt.x);
            else
                send('{op: (row.op == ROW_LOAD) ? OP_LOAD : OP_QUERY, pt: row.pt},
                     row.how, row.match);
        end

        // Random segments, each under its own tolerance.
        centers[0] = '0;
        centers[1] = CMAX;
        centers[2] = COORD_W'($urandom());
        centers[3] = COORD_W'($urandom());
        for (seg = 0; seg < SEGMENTS; seg++)
        begin
            case (seg)
                0: seg_tol = $urandom_range(500, 4000);
                1: seg_tol = TOL_MAX;
                2: seg_tol = '0;
                3: seg_tol = 1;
                4: seg_tol = TOL_W'($urandom());
                5: seg_tol = $urandom_range(100, 2000);
                6: seg_tol = TOL_MAX;
                7: seg_tol = $urandom_range(2000, 20000);
                default: seg_tol = TOL_RESET;
            endcase
            set_tolerance(seg_tol);
            n = SEGMENT_ITEMS;
            if (seg == 1)
            begin
                // The result side holds off while matching queries keep coming.
                hold_off_cycles = HOLD_CYCLES;
                pace_on = 1'b0;
                repeat (12) send(near_query(), EXP_MODEL, none);
                pace_on = 1'b1;
                n = SEGMENT_ITEMS - 12;
            end
            repeat (n) send(random_request(), EXP_MODEL, none);
        end

        // Fill the table, overfill it, then query the full table.
        set_tolerance(3000);
        while (stored_count < MAX_POINTS)
            send(random_load(), EXP_MODEL, none);
        repeat (3) send('{op: OP_LOAD, pt: point_t'({$urandom(), $urandom(), $urandom(),
                         $urandom()})}, EXP_MODEL, none);
        repeat (6) send(near_query(), EXP_MODEL, none);
        send('{op: OP_QUERY, pt: '{delta: 0, time_val: 0, y: tbl_y[MAX_POINTS-1],
                                   x: tbl_x[MAX_POINTS-1]}}, EXP_MODEL, none);
        set_tolerance(TOL_MAX);
        repeat (3) send(near_query(), EXP_MODEL, none);

        wait_idle();
        if (pending_matches.size() != 0)
        begin
            $error("%0d expected matches never arrived", pending_matches.size());
            error_count++;
        end

        $display("Covered %0d loads (%0d dropped on a full table) and %0d queries,",
                 loads_sent, loads_dropped, queries_sent);
        $display("%0d matches checked under %0d tolerance settings, %0d errors.",
                 matches_seen, tol_settings, error_count);
        if (error_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ===== nearest_point_within_tolerance.f =====
rtl/core/npwt_pkg.sv
rtl/core/npwt_front.sv
rtl/core/npwt_back.sv
rtl/core/nearest_point_within_tolerance.sv
rtl/core/npwt_checker.sv
tb/sv/testbench.sv
